@@ rtl/core/ecpg_pkg.sv @@
// Package for the four-channel pulse generator: shared widths, register
// indexes, reset values and the lane control struct.
// No dependencies.
package ecpg_pkg;

    localparam int CHANNELS        = 4;
    localparam int CMD_WIDTH       = 12;
    localparam int LIMIT_WIDTH     = 11;
    localparam int TIME_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_FRAME  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_LEN   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_LIMIT = 2'd2;

    localparam logic [TIME_WIDTH-1:0]  MIN_FRAME_RESET  = 16'd2500;
    localparam logic [TIME_WIDTH-1:0]  BASE_LEN_RESET   = 16'd1000;
    localparam logic [LIMIT_WIDTH-1:0] HIGH_LIMIT_RESET = 11'd1000;

    // Control from the sequencer to every channel lane for one request.
    typedef struct packed {
        logic step;   // state advances for this request
        logic load;   // latch a fresh command
        logic start;  // frame begins: drive the line high
        logic eval;   // command part: test the line against the count
    } lane_ctrl_t;

endpackage

@@ rtl/core/ecpg_if.sv @@
// Channel interfaces of the pulse generator: request, result and
// configuration write. Depends on ecpg_pkg.
interface ecpg_req_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       req_type;
    logic signed [ecpg_pkg::CMD_WIDTH-1:0]      cmd_one;
    logic signed [ecpg_pkg::CMD_WIDTH-1:0]      cmd_two;
    logic signed [ecpg_pkg::CMD_WIDTH-1:0]      cmd_three;
    logic signed [ecpg_pkg::CMD_WIDTH-1:0]      cmd_four;

    modport source (output valid, req_type, cmd_one, cmd_two, cmd_three, cmd_four,
                    input ready);
    modport sink (input valid, req_type, cmd_one, cmd_two, cmd_three, cmd_four,
                  output ready);
endinterface

interface ecpg_res_if;
    logic valid;
    logic ready;
    logic line_one;
    logic line_two;
    logic line_three;
    logic line_four;
    logic busy_res;
    logic accepted;

    modport source (output valid, line_one, line_two, line_three, line_four,
                    busy_res, accepted, input ready);
    modport sink (input valid, line_one, line_two, line_three, line_four,
                  busy_res, accepted, output ready);
endinterface

interface ecpg_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [ecpg_pkg::CFG_INDEX_WIDTH-1:0]       index;
    logic [ecpg_pkg::CFG_DATA_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ecpg_lane.sv @@
// One channel lane: clamps and latches its command, holds its line level
// and decides when the line drops. Depends on ecpg_pkg.
module ecpg_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ecpg_pkg::lane_ctrl_t                    ctrl,
    input  logic [COUNT_WIDTH-1:0]                  count,
    input  logic signed [ecpg_pkg::CMD_WIDTH-1:0]   cmd,
    input  logic [ecpg_pkg::LIMIT_WIDTH-1:0]        high_limit,
    output logic                                    level_next
);

    localparam int CMPW = (COUNT_WIDTH > ecpg_pkg::LIMIT_WIDTH) ?
                          COUNT_WIDTH : ecpg_pkg::LIMIT_WIDTH;

    logic [ecpg_pkg::LIMIT_WIDTH-1:0] cmd_reg;
    logic                             level_reg;
    logic [ecpg_pkg::LIMIT_WIDTH-1:0] cmd_clamped;
    logic [ecpg_pkg::LIMIT_WIDTH-1:0] cmd_eff;
    logic                             drop;
    logic                             level_base;

    always_comb
    begin
        if (cmd[ecpg_pkg::CMD_WIDTH-1])
            cmd_clamped = '0;
        else if (cmd[ecpg_pkg::LIMIT_WIDTH-1:0] > high_limit)
            cmd_clamped = high_limit;
        else
            cmd_clamped = cmd[ecpg_pkg::LIMIT_WIDTH-1:0];
    end

    // A fresh command may be tested in the same request that loads it.
    assign cmd_eff    = ctrl.load ? cmd_clamped : cmd_reg;
    assign drop       = (CMPW'(count) >= CMPW'(cmd_eff)) || (count == '1);
    assign level_base = ctrl.start ? 1'b1 : level_reg;
    assign level_next = (ctrl.eval && drop) ? 1'b0 : level_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.step)
                level_reg <= level_next;
            if (ctrl.load)
                cmd_reg <= cmd_clamped;
        end
    end

endmodule

@@ rtl/core/ecpg_ctrl.sv @@
// Frame sequencer: phase state machine, elapsed and phase counters, and the
// merge of the lane levels that ends a frame. Depends on ecpg_pkg.
module ecpg_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic                                req_type,
    input  logic [ecpg_pkg::TIME_WIDTH-1:0]     min_frame,
    input  logic [ecpg_pkg::TIME_WIDTH-1:0]     base_len,
    input  logic                                lines_any,
    output ecpg_pkg::lane_ctrl_t                lane_ctrl,
    output logic [COUNT_WIDTH-1:0]              count,
    output logic                                busy,
    output logic                                accepted
);

    localparam int CMPW = (COUNT_WIDTH > ecpg_pkg::TIME_WIDTH) ?
                          COUNT_WIDTH : ecpg_pkg::TIME_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_BASE,
        PH_CMD
    } phase_t;

    phase_t                  phase_reg, phase_mid, phase_next;
    logic [COUNT_WIDTH-1:0]  pc_reg, pc_mid, pc_next;
    logic [COUNT_WIDTH-1:0]  since_reg, since_next;
    logic                    acc_mid;

    // Apply the request, then settle every phase change that needs no tick.
    always_comb
    begin
        phase_mid  = phase_reg;
        pc_mid     = pc_reg;
        since_next = since_reg;
        acc_mid    = 1'b0;
        lane_ctrl  = '0;
        if (take)
        begin
            if (req_type)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    lane_ctrl.load = 1'b1;
                    lane_ctrl.step = 1'b1;
                    phase_mid      = PH_WAIT;
                    pc_mid         = '0;
                    acc_mid        = 1'b1;
                end
            end
            else
            begin
                lane_ctrl.step = 1'b1;
                if (since_reg != '1)
                    since_next = since_reg + 1'b1;
                if ((phase_reg == PH_BASE || phase_reg == PH_CMD) && pc_reg != '1)
                    pc_mid = pc_reg + 1'b1;
            end
        end
        if (lane_ctrl.step)
        begin
            if (phase_mid == PH_WAIT &&
                (CMPW'(since_next) >= CMPW'(min_frame) || since_next == '1))
            begin
                lane_ctrl.start = 1'b1;
                since_next      = '0;
                pc_mid          = '0;
                phase_mid       = PH_BASE;
            end
            if (phase_mid == PH_BASE &&
                (CMPW'(pc_mid) >= CMPW'(base_len) || pc_mid == '1))
            begin
                pc_mid    = '0;
                phase_mid = PH_CMD;
            end
            if (phase_mid == PH_CMD)
                lane_ctrl.eval = 1'b1;
        end
    end

    assign count = pc_mid;

    // The frame ends once every lane has dropped its line.
    always_comb
    begin
        phase_next = phase_mid;
        pc_next    = pc_mid;
        if (lane_ctrl.eval && !lines_any)
        begin
            phase_next = PH_IDLE;
            pc_next    = '0;
        end
    end

    assign busy     = (phase_next != PH_IDLE);
    assign accepted = acc_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pc_reg    <= '0;
            since_reg <= '1;
        end
        else if (lane_ctrl.step)
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            since_reg <= since_next;
        end
    end

endmodule

@@ rtl/core/four_channel_esc_pulse_generator_top.sv @@
// Top level of the four-channel pulse generator: configuration registers,
// channel lanes, sequencer and the result register.
// Depends on ecpg_pkg, ecpg_if, ecpg_lane and ecpg_ctrl.
//
//  Port  | Direction | Carries
//  ------+-----------+---------------------------------------------------
//  req   | sink      | tick or frame request with four signed commands
//  res   | source    | four line levels, busy flag, request-taken flag
//  cfg   | sink      | register write: index and data, always ready
//
// Results are registered; a request is taken each cycle with req.ready.
// The lane compare and the end-of-frame merge set the cycle's depth.
// A result sits in the output register until taken; req.ready is high
// whenever that register is empty or is being emptied in the same cycle.
// Reset clears the state to idle with the elapsed count saturated.
module four_channel_esc_pulse_generator_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    ecpg_req_if.sink        req,
    ecpg_res_if.source      res,
    ecpg_cfg_if.sink        cfg
);

    logic [ecpg_pkg::TIME_WIDTH-1:0]        min_frame_reg;
    logic [ecpg_pkg::TIME_WIDTH-1:0]        base_len_reg;
    logic [ecpg_pkg::LIMIT_WIDTH-1:0]       high_limit_reg;

    logic                                   take;
    logic                                   res_valid_reg;
    logic [ecpg_pkg::CHANNELS-1:0]          line_reg;
    logic                                   busy_reg;
    logic                                   acc_reg;

    logic signed [ecpg_pkg::CMD_WIDTH-1:0]  cmd_arr [ecpg_pkg::CHANNELS];
    logic [ecpg_pkg::CHANNELS-1:0]          level_next;
    ecpg_pkg::lane_ctrl_t                   lane_ctrl;
    logic [COUNT_WIDTH-1:0]                 count;
    logic                                   busy;
    logic                                   accepted;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_reg  <= ecpg_pkg::MIN_FRAME_RESET;
            base_len_reg   <= ecpg_pkg::BASE_LEN_RESET;
            high_limit_reg <= ecpg_pkg::HIGH_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ecpg_pkg::REG_MIN_FRAME: min_frame_reg <= cfg.data;
                ecpg_pkg::REG_BASE_LEN:  base_len_reg  <= cfg.data;
                ecpg_pkg::REG_HIGH_LIMIT:
                    high_limit_reg <= cfg.data[ecpg_pkg::LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign req.ready = !res_valid_reg || res.ready;
    assign take      = req.valid && req.ready;

    assign cmd_arr[0] = req.cmd_one;
    assign cmd_arr[1] = req.cmd_two;
    assign cmd_arr[2] = req.cmd_three;
    assign cmd_arr[3] = req.cmd_four;

    for (genvar k = 0; k < ecpg_pkg::CHANNELS; k++)
    begin : g_lane
        ecpg_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .count      (count),
            .cmd        (cmd_arr[k]),
            .high_limit (high_limit_reg),
            .level_next (level_next[k])
        );
    end

    ecpg_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .req_type   (req.req_type),
        .min_frame  (min_frame_reg),
        .base_len   (base_len_reg),
        .lines_any  (|level_next),
        .lane_ctrl  (lane_ctrl),
        .count      (count),
        .busy       (busy),
        .accepted   (accepted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (take)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            line_reg <= level_next;
            busy_reg <= busy;
            acc_reg  <= accepted;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.line_one   = line_reg[0];
    assign res.line_two   = line_reg[1];
    assign res.line_three = line_reg[2];
    assign res.line_four  = line_reg[3];
    assign res.busy_res   = busy_reg;
    assign res.accepted   = acc_reg;

endmodule

@@ rtl/core/ecpg_checker.sv @@
// Port-level checks for the pulse generator and the bind that attaches them.
// Depends on ecpg_if and four_channel_esc_pulse_generator_top.
module ecpg_checker (
    input  logic            clk,
    input  logic            rst_n,
    ecpg_req_if.sink        req,
    ecpg_res_if.source      res
);

    // A line is high only while a frame is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.line_one || res.line_two || res.line_three || res.line_four)
        |-> res.busy_res)
    else $error("line high while not busy");

    // A tick never reports a taken frame request.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && !req.req_type |=> res.valid && !res.accepted)
    else $error("tick reported as accepted request");

    // An empty result register never holds back a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !res.valid |-> req.ready)
    else $error("request stalled with empty result register");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.line_one)
        && $stable(res.line_two) && $stable(res.line_three) && $stable(res.line_four)
        && $stable(res.busy_res) && $stable(res.accepted))
    else $error("stalled result changed");

endmodule

bind four_channel_esc_pulse_generator_top ecpg_checker u_ecpg_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
);

@@ tb/sv/ecpg_frame_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the four-channel pulse generator: follows register writes
// and requests, predicts every result and compares it with what the block sends.
// Depends on ecpg_pkg and the channel interfaces in ecpg_if.
module ecpg_frame_checker
    import ecpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ecpg_req_if  req,
    ecpg_res_if  res,
    ecpg_cfg_if  cfg,
    output int   fail_count,
    output int   outstanding
);

    localparam logic [TIME_WIDTH-1:0] COUNT_MAX = '1;
    localparam int REPORT_LINES = 40;

    typedef enum logic [1:0] {FRAME_IDLE, FRAME_WAIT, FRAME_BASE, FRAME_CMD} frame_phase_t;

    typedef struct packed {
        logic                               is_frame;
        logic [CHANNELS-1:0][CMD_WIDTH-1:0] cmd;
    } pulse_req_t;

    typedef struct packed {
        logic [CHANNELS-1:0] lines;
        logic                busy;
        logic                taken;
    } pulse_res_t;

    logic [TIME_WIDTH-1:0]  min_gap;
    logic [TIME_WIDTH-1:0]  base_len;
    logic [LIMIT_WIDTH-1:0] cmd_ceiling;

    frame_phase_t           phase;
    logic [TIME_WIDTH-1:0]  part_count;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic [LIMIT_WIDTH-1:0] held_cmd [CHANNELS];
    logic [CHANNELS-1:0]    levels;

    pulse_res_t levels_due[$];
    int         mismatches = 0;
    int         result_no = 0;

    assign fail_count = mismatches;

    task automatic report(string what, int got, int want);
        if (mismatches < REPORT_LINES)
            $display("%0t: result %0d: %s is %0d, predicted %0d",
                     $time, result_no, what, got, want);
        mismatches++;
    endtask

    // Every phase change that needs no further tick happens within the same request.
    function automatic void settle_frame();
        if (phase == FRAME_WAIT && (elapsed >= min_gap || elapsed == COUNT_MAX))
        begin
            levels     = '1;
            elapsed    = '0;
            part_count = '0;
            phase      = FRAME_BASE;
        end
        if (phase == FRAME_BASE && (part_count >= base_len || part_count == COUNT_MAX))
        begin
            part_count = '0;
            phase      = FRAME_CMD;
        end
        if (phase == FRAME_CMD)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (part_count >= TIME_WIDTH'(held_cmd[k]) || part_count == COUNT_MAX)
                    levels[k] = 1'b0;
            end
            if (levels == '0)
            begin
                part_count = '0;
                phase      = FRAME_IDLE;
            end
        end
    endfunction

    function automatic pulse_res_t predict_levels(pulse_req_t item);
        pulse_res_t r;
        r.taken = 1'b0;
        if (item.is_frame)
        begin
            // A request during a frame is refused and no time passes.
            if (phase == FRAME_IDLE)
            begin
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (item.cmd[k][CMD_WIDTH-1])
                        held_cmd[k] = '0;
                    else if (item.cmd[k][LIMIT_WIDTH-1:0] > cmd_ceiling)
                        held_cmd[k] = cmd_ceiling;
                    else
                        held_cmd[k] = item.cmd[k][LIMIT_WIDTH-1:0];
                end
                phase      = FRAME_WAIT;
                part_count = '0;
                r.taken    = 1'b1;
                settle_frame();
            end
        end
        else
        begin
            if (elapsed != COUNT_MAX)
                elapsed = elapsed + 1'b1;
            if ((phase == FRAME_BASE || phase == FRAME_CMD) && part_count != COUNT_MAX)
                part_count = part_count + 1'b1;
            settle_frame();
        end
        r.lines = levels;
        r.busy  = (phase != FRAME_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_req_t item;
        pulse_res_t got;
        pulse_res_t want;
        if (!rst_n)
        begin
            min_gap     = MIN_FRAME_RESET;
            base_len    = BASE_LEN_RESET;
            cmd_ceiling = HIGH_LIMIT_RESET;
            phase       = FRAME_IDLE;
            part_count  = '0;
            elapsed     = COUNT_MAX;
            for (int k = 0; k < CHANNELS; k++)
                held_cmd[k] = '0;
            levels = '0;
            levels_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MIN_FRAME:  min_gap     = cfg.data[TIME_WIDTH-1:0];
                    REG_BASE_LEN:   base_len    = cfg.data[TIME_WIDTH-1:0];
                    REG_HIGH_LIMIT: cmd_ceiling = cfg.data[LIMIT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                got.lines = {res.line_four, res.line_three, res.line_two, res.line_one};
                got.busy  = res.busy_res;
                got.taken = res.accepted;
                if (levels_due.size() == 0)
                    report("result with nothing predicted, lines", got.lines, 0);
                else
                begin
                    want = levels_due.pop_front();
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        if (got.lines[k] !== want.lines[k])
                            report($sformatf("line %0d", k + 1), got.lines[k], want.lines[k]);
                    end
                    if (got.busy !== want.busy)
                        report("busy flag", got.busy, want.busy);
                    if (got.taken !== want.taken)
                        report("accepted flag", got.taken, want.taken);
                end
                result_no++;
            end
            if (req.valid && req.ready)
            begin
                item.is_frame = req.req_type;
                item.cmd[0]   = req.cmd_one;
                item.cmd[1]   = req.cmd_two;
                item.cmd[2]   = req.cmd_three;
                item.cmd[3]   = req.cmd_four;
                levels_due.push_back(predict_levels(item));
            end
            outstanding <= levels_due.size();
        end
    end

endmodule

@@ tb/sv/tb_four_channel_esc_pulse_generator_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the four-channel pulse generator: clock, reset, register
// writes and request stimulus under varied pacing, and the verdict.
// Depends on ecpg_pkg, ecpg_if, the block itself and ecpg_frame_checker.
module tb_four_channel_esc_pulse_generator_top;
    import ecpg_pkg::*;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef enum int {PACE_FREE, PACE_SLOW_SOURCE, PACE_SLOW_SINK, PACE_BOTH} pacing_t;

    logic clk;
    logic rst_n;
    int   source_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   hold_off_left = 0;
    int   cur_ceiling = 0;
    int   fail_count;
    int   outstanding;

    ecpg_req_if req_ch ();
    ecpg_res_if res_ch ();
    ecpg_cfg_if cfg_ch ();

    four_channel_esc_pulse_generator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    ecpg_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, or a long hold-off that fills the block up.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left = hold_off_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic set_pacing(pacing_t mode);
        source_idle_pct = (mode == PACE_SLOW_SOURCE) ? 68 : (mode == PACE_BOTH) ? 9 : 0;
        sink_stall_pct  = (mode == PACE_SLOW_SINK) ? 68 : (mode == PACE_BOTH) ? 9 : 0;
    endtask

    task automatic put_request(logic kind, logic [CMD_WIDTH-1:0] c1, logic [CMD_WIDTH-1:0] c2,
                               logic [CMD_WIDTH-1:0] c3, logic [CMD_WIDTH-1:0] c4);
        while ($urandom_range(99) < source_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.cmd_one   <= c1;
        req_ch.cmd_two   <= c2;
        req_ch.cmd_three <= c3;
        req_ch.cmd_four  <= c4;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // The unused index is written first; the block must ignore it.
    task automatic program_registers(logic [CFG_DATA_WIDTH-1:0] min_ticks,
                                     logic [CFG_DATA_WIDTH-1:0] base_ticks,
                                     logic [CFG_DATA_WIDTH-1:0] limit_word);
        logic [CFG_INDEX_WIDTH-1:0] idx [4];
        logic [CFG_DATA_WIDTH-1:0]  val [4];
        idx = '{REG_SPARE, REG_MIN_FRAME, REG_BASE_LEN, REG_HIGH_LIMIT};
        val = '{CFG_DATA_WIDTH'($urandom), min_ticks, base_ticks, limit_word};
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        cur_ceiling = limit_word[LIMIT_WIDTH-1:0];
    endtask

    task automatic await_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CMD_WIDTH-1:0] random_cmd();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return CMD_WIDTH'($urandom_range(cur_ceiling + 3));
            5, 6:          return CMD_WIDTH'(-int'($urandom_range(2048, 1)));
            7:             return CMD_WIDTH'($urandom);
            8:             return ($urandom_range(1) != 0) ? {1'b0, {(CMD_WIDTH-1){1'b1}}}
                                                           : {1'b1, {(CMD_WIDTH-1){1'b0}}};
            default:       return CMD_WIDTH'(cur_ceiling);
        endcase
    endfunction

    task automatic run_random(int count, int frame_pct);
        for (int n = 0; n < count; n++)
            put_request(($urandom_range(99) < frame_pct) ? KIND_FRAME : KIND_TICK,
                        random_cmd(), random_cmd(), random_cmd(), random_cmd());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = KIND_TICK;
        req_ch.cmd_one   = '0;
        req_ch.cmd_two   = '0;
        req_ch.cmd_three = '0;
        req_ch.cmd_four  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_MIN_FRAME;
        cfg_ch.data      = '0;
        set_pacing(PACE_FREE);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first frame starts at once, since the elapsed count leaves reset
        // saturated. Negative commands drop their line right after the base part.
        program_registers(16'd6, 16'd2, 16'hffff);
        put_request(KIND_FRAME, 12'd3, 12'h800, 12'd0, 12'd1);
        put_request(KIND_FRAME, 12'd5, 12'd5, 12'd5, 12'd5);
        repeat (5) put_request(KIND_TICK, '0, '0, '0, '0);
        put_request(KIND_FRAME, 12'd9, 12'hfff, 12'd2, 12'd0);
        repeat (12) put_request(KIND_TICK, '0, '0, '0, '0);
        await_quiet();

        // Zero spacing, zero base and a zero ceiling: each frame ends in its own request.
        program_registers(16'd0, 16'd0, 16'hf800);
        put_request(KIND_FRAME, 12'h7ff, 12'h800, 12'd1, 12'hfff);
        put_request(KIND_TICK, '1, '1, '1, '1);
        put_request(KIND_FRAME, 12'd0, 12'd0, 12'd0, 12'd0);
        put_request(KIND_TICK, '0, '0, '0, '0);

        for (int p = 0; p < 10; p++)
        begin
            await_quiet();
            set_pacing(pacing_t'(p % 4));
            case (p)
                0: program_registers(16'd12, 16'd4, 16'd10);
                1: program_registers(16'd0, 16'd0, 16'd0);
                2: program_registers(16'hffff, 16'd3, 16'd8);
                3: program_registers(16'd0, 16'hffff, 16'd5);
                4: program_registers(16'd0, 16'd0, {5'($urandom), 11'h7ff});
                default: program_registers(16'($urandom_range(40)), 16'($urandom_range(20)),
                                           {5'($urandom), 11'($urandom_range(24))});
            endcase
            if (p == 8)
                hold_off_left = HOLD_OFF_CYCLES;
            run_random((p == 4) ? 600 : (p == 2 || p == 3) ? 100 : 200, (p == 4) ? 4 : 15);
        end
        await_quiet();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
